FILE: design/gonw_pkg.sv
package gonw_pkg;

  // Storage side of the square wall bitmap
  localparam int MAX_SIDE = 64;
  localparam int SIDE_W   = $clog2(MAX_SIDE);
  localparam int SIZE_W   = SIDE_W + 1;
  localparam int ADDR_W   = 2 * SIDE_W;
  localparam int MEM_D    = 1 << ADDR_W;

  // Fixed field widths
  localparam int CELL_W   = 6;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;
  localparam int FDIST_W  = 11;
  localparam int OPEN_W   = 17;

  // Index width wide enough for both the field and the storage side
  localparam int IDX_W    = (SIDE_W > CELL_W) ? SIDE_W : CELL_W;
  localparam int CMP_W    = IDX_W + 1;

  // Squared distance register, never narrower than the result field
  localparam int SQ_W     = 2 * SIDE_W;
  localparam int DIST_W   = (SQ_W + 1 > FDIST_W) ? SQ_W + 1 : FDIST_W;
  localparam int FDIST_MAX = (1 << FDIST_W) - 1;

  // Reciprocal: numerator (1.0 + d/2) stays below 2^17 for every legal side
  localparam int NUM_W    = OPEN_W;
  localparam int CNT_W    = $clog2(NUM_W);
  localparam int ONE_Q16  = 65536;

  localparam int ROWS_RESET = 40;
  localparam int COLS_RESET = 40;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [CELL_W-1:0] cell_row;
    logic [CELL_W-1:0] cell_col;
    logic              wall_bit;
  } in_t;

  typedef struct packed {
    logic               marked;
    logic [FDIST_W-1:0] nearest_dist_sq;
    logic [OPEN_W-1:0]  openness;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_INIT,
    ST_SCAN,
    ST_DRAIN,
    ST_RECIP,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic clr_wr;
    logic load_wr;
    logic cnt_zero;
    logic step_full;
    logic scan_rd;
    logic init_best;
    logic zero_res;
    logic recip_load;
    logic div_step;
  } ctrl_t;

  typedef struct packed {
    logic in_map;
    logic last_full;
    logic last_map;
    logic pipe_empty;
    logic best_zero;
    logic div_last;
  } stat_t;

  function automatic logic [SIZE_W-1:0] used_size(input logic [CFG_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (int'(v) > MAX_SIDE) begin
      r = SIZE_W'(MAX_SIDE);
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: design/grid_openness_nearest_wall_unit.sv
// Channel   Signals                          Handshake
// -------   ------------------------------   ------------------------------------
// item      item (cmd, cell_row, cell_col,   beat taken on start && !busy
//           wall_bit)
// result    result (marked, nearest_dist_sq, beat shown for one cycle with done
//           openness)
// config    cfg_we, cfg_index, cfg_data      written on cfg_we, no wait
//
// A load beat gives no result. A query sets up, scans rows*cols cells (one
// bitmap cell per cycle from the single read port), drains the pipeline,
// runs the divider for the reciprocal and shows its result. A query of a wall
// cell skips the divider; queries outside the map skip the scan and the divider.
// After reset the bitmap is cleared one cell per cycle over all 4096 storage
// cells; busy stays high meanwhile. Results cannot be held off; a new beat is
// taken in the cycle its predecessor's result is shown.
module grid_openness_nearest_wall_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  gonw_pkg::in_t                    item,
  output logic                             done,
  output gonw_pkg::out_t                   result,
  input  logic                             cfg_we,
  input  logic [gonw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gonw_pkg::CFG_W-1:0]       cfg_data
);
  import gonw_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  gonw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_cmd (item.cmd),
    .stat      (stat),
    .ctrl      (ctrl),
    .busy      (busy),
    .done      (done)
  );

  gonw_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  a_marked_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && result.marked |-> result.nearest_dist_sq != '0 && result.openness != '0)
    else $error("marked result with zero distance or openness");

  a_unmarked_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.marked |-> result.nearest_dist_sq == '0 && result.openness == '0)
    else $error("unmarked result carries a value");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not start work");

endmodule

FILE: design/gonw_ctrl.sv
module gonw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            start_cmd,
  input  gonw_pkg::stat_t stat,
  output gonw_pkg::ctrl_t ctrl,
  output logic            busy,
  output logic            done
);
  import gonw_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ctrl.clr_wr    = 1'b1;
        ctrl.step_full = 1'b1;
        if (stat.last_full) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE, ST_OUT: begin
        busy = 1'b0;
        done = (state == ST_OUT);
        if (start) begin
          ctrl.latch = 1'b1;
          state_next = (start_cmd == CMD_LOAD) ? ST_LOAD : ST_INIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_LOAD: begin
        ctrl.load_wr = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_INIT: begin
        if (stat.in_map) begin
          ctrl.init_best = 1'b1;
          ctrl.cnt_zero  = 1'b1;
          state_next     = ST_SCAN;
        end else begin
          ctrl.zero_res = 1'b1;
          state_next    = ST_OUT;
        end
      end
      ST_SCAN: begin
        ctrl.scan_rd = 1'b1;
        if (stat.last_map) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          state_next = ST_RECIP;
        end
      end
      ST_RECIP: begin
        // a zero distance means the queried cell itself is a wall
        if (stat.best_zero) begin
          ctrl.zero_res = 1'b1;
          state_next    = ST_OUT;
        end else begin
          ctrl.recip_load = 1'b1;
          state_next      = ST_DIV;
        end
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_OUT;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/gonw_datapath.sv
module gonw_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  gonw_pkg::ctrl_t                  ctrl,
  output gonw_pkg::stat_t                  stat,
  input  gonw_pkg::in_t                    item,
  input  logic                             cfg_we,
  input  logic [gonw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gonw_pkg::CFG_W-1:0]       cfg_data,
  output gonw_pkg::out_t                   result
);
  import gonw_pkg::*;

  logic [CFG_W-1:0]  map_rows, map_cols;
  logic [SIZE_W-1:0] rows_used, cols_used;

  in_t               req;
  logic [IDX_W-1:0]  row_x, col_x;
  logic [SIDE_W-1:0] qrow, qcol;
  logic              in_store;

  logic              mem [MEM_D];
  logic              rd_bit;
  logic              wr_en, wr_bit;
  logic [ADDR_W-1:0] wr_addr;

  logic [SIDE_W-1:0] sr, sc;

  logic              p1, p2;
  logic [SIDE_W-1:0] p1_r, p1_c, dr, dc;
  logic [SQ_W-1:0]   sq_r, sq_c;
  logic [DIST_W-1:0] sum, best;

  logic [SIZE_W-1:0] bd_a, bd_b, bd_c, bd_d, bd_ab, bd_cd, bd_m;

  logic              marked;
  logic [NUM_W-1:0]  num, quot;
  logic [DIST_W-1:0] rem;
  logic [DIST_W:0]   trial;
  logic              ge;
  logic [CNT_W-1:0]  div_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_rows <= CFG_W'(ROWS_RESET);
      map_cols <= CFG_W'(COLS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_ROWS: map_rows <= cfg_data;
        REG_MAP_COLS: map_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows_used = used_size(map_rows);
  assign cols_used = used_size(map_cols);

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      req <= item;
    end
  end

  assign row_x    = IDX_W'(req.cell_row);
  assign col_x    = IDX_W'(req.cell_col);
  assign qrow     = row_x[SIDE_W-1:0];
  assign qcol     = col_x[SIDE_W-1:0];
  assign in_store = (CMP_W'(row_x) < CMP_W'(MAX_SIDE)) &&
                    (CMP_W'(col_x) < CMP_W'(MAX_SIDE));

  assign stat.in_map = (CMP_W'(row_x) < CMP_W'(rows_used)) &&
                       (CMP_W'(col_x) < CMP_W'(cols_used));

  // Wall bitmap: one write port for clear and load, one registered read for the scan
  assign wr_en   = ctrl.clr_wr | (ctrl.load_wr & in_store);
  assign wr_bit  = ctrl.clr_wr ? 1'b0 : req.wall_bit;
  assign wr_addr = ctrl.clr_wr ? {sr, sc} : {qrow, qcol};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    rd_bit <= mem[{sr, sc}];
  end

  // Scan position; the clear sweep wraps over the whole storage
  always_ff @(posedge clk) begin
    if (rst || ctrl.cnt_zero) begin
      sr <= '0;
      sc <= '0;
    end else if (ctrl.step_full) begin
      sc <= sc + 1'b1;
      if (&sc) begin
        sr <= sr + 1'b1;
      end
    end else if (ctrl.scan_rd) begin
      if (sc == SIDE_W'(cols_used - 1'b1)) begin
        sc <= '0;
        sr <= sr + 1'b1;
      end else begin
        sc <= sc + 1'b1;
      end
    end
  end

  assign stat.last_full = &{sr, sc};
  assign stat.last_map  = (sr == SIDE_W'(rows_used - 1'b1)) &&
                          (sc == SIDE_W'(cols_used - 1'b1));

  // Stage 1: memory read in flight; stage 2: squares; stage 3: compare
  assign dr  = (p1_r > qrow) ? (p1_r - qrow) : (qrow - p1_r);
  assign dc  = (p1_c > qcol) ? (p1_c - qcol) : (qcol - p1_c);
  assign sum = DIST_W'(sq_r) + DIST_W'(sq_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
    end else begin
      p1 <= ctrl.scan_rd;
      p2 <= p1 & rd_bit;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= sr;
    p1_c <= sc;
    sq_r <= dr * dr;
    sq_c <= dc * dc;
  end

  assign stat.pipe_empty = ~p1 & ~p2;

  // Nearest border ring cell: square of the smallest edge gap
  assign bd_a  = SIZE_W'(qrow) + 1'b1;
  assign bd_b  = SIZE_W'(qcol) + 1'b1;
  assign bd_c  = rows_used - SIZE_W'(qrow);
  assign bd_d  = cols_used - SIZE_W'(qcol);
  assign bd_ab = (bd_a < bd_b) ? bd_a : bd_b;
  assign bd_cd = (bd_c < bd_d) ? bd_c : bd_d;
  assign bd_m  = (bd_ab < bd_cd) ? bd_ab : bd_cd;

  always_ff @(posedge clk) begin
    if (ctrl.init_best) begin
      best <= DIST_W'(bd_m) * DIST_W'(bd_m);
    end else if (p2 && (sum < best)) begin
      best <= sum;
    end
  end

  assign stat.best_zero = (best == '0);

  // Restoring division, one quotient bit per cycle
  assign trial = {rem, num[NUM_W-1]};
  assign ge    = (trial >= {1'b0, best});

  always_ff @(posedge clk) begin
    if (ctrl.recip_load) begin
      num     <= NUM_W'(ONE_Q16) + NUM_W'(best >> 1);
      rem     <= '0;
      quot    <= '0;
      div_cnt <= CNT_W'(NUM_W - 1);
    end else if (ctrl.div_step) begin
      rem     <= ge ? DIST_W'(trial - {1'b0, best}) : DIST_W'(trial);
      num     <= num << 1;
      quot    <= {quot[NUM_W-2:0], ge};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  assign stat.div_last = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst || ctrl.zero_res) begin
      marked <= 1'b0;
    end else if (ctrl.recip_load) begin
      marked <= 1'b1;
    end
  end

  assign result.marked          = marked;
  assign result.nearest_dist_sq = !marked ? '0 :
                                  (best > DIST_W'(FDIST_MAX)) ? FDIST_W'(FDIST_MAX) :
                                  best[FDIST_W-1:0];
  assign result.openness        = marked ? quot : '0;

endmodule

FILE: bench/testbench.sv
module testbench;
  import gonw_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 7;
  localparam int BEATS_PER_PHASE = 17;
  localparam int IN_W         = $bits(in_t);

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t item = '0;
  logic done;
  out_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Copy of the bitmap and size registers as the block should hold them
  bit wall_copy [MAX_SIDE*MAX_SIDE];
  logic [CFG_W-1:0] rows_cfg = CFG_W'(ROWS_RESET);
  logic [CFG_W-1:0] cols_cfg = CFG_W'(COLS_RESET);
  out_t pending_openness [$];

  int mismatches = 0;
  int cycle_cnt = 0;
  bit idle_on = 1'b1;
  int cur_rows = ROWS_RESET;
  int cur_cols = COLS_RESET;

  grid_openness_nearest_wall_unit i_dut (
    .clk, .rst, .start, .busy, .item, .done, .result, .cfg_we, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic int clamp_side(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic out_t nearest_wall_openness(input in_t q);
    out_t res = '0;
    int rows, cols, r0, c0, best, d;
    rows = clamp_side(rows_cfg);
    cols = clamp_side(cols_cfg);
    r0 = q.cell_row;
    c0 = q.cell_col;
    if (r0 >= rows || c0 >= cols || wall_copy[r0*MAX_SIDE + c0]) return res;
    // border ring sits one cell outside the used map on every side
    best = (r0 + 1) * (r0 + 1);
    d = (c0 + 1) * (c0 + 1);
    if (d < best) best = d;
    d = (rows - r0) * (rows - r0);
    if (d < best) best = d;
    d = (cols - c0) * (cols - c0);
    if (d < best) best = d;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (wall_copy[r*MAX_SIDE + c]) begin
          d = (r - r0) * (r - r0) + (c - c0) * (c - c0);
          if (d < best) best = d;
        end
      end
    end
    res.marked = 1'b1;
    res.nearest_dist_sq = (best > FDIST_MAX) ? FDIST_W'(FDIST_MAX) : FDIST_W'(best);
    res.openness = OPEN_W'((ONE_Q16 + best / 2) / best);
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    if (!rst) begin
      if (done) begin
        if (pending_openness.size() == 0) begin
          note_mismatch($sformatf("result %p with no query waiting", result));
        end else begin
          want = pending_openness.pop_front();
          if (result.marked !== want.marked)
            note_mismatch($sformatf("marked %b, want %b", result.marked, want.marked));
          if (result.nearest_dist_sq !== want.nearest_dist_sq)
            note_mismatch($sformatf("nearest_dist_sq %0d, want %0d",
                                    result.nearest_dist_sq, want.nearest_dist_sq));
          if (result.openness !== want.openness)
            note_mismatch($sformatf("openness %0d, want %0d",
                                    result.openness, want.openness));
        end
      end
      if (start && !busy) begin
        if (item.cmd == CMD_LOAD) begin
          wall_copy[item.cell_row*MAX_SIDE + item.cell_col] = item.wall_bit;
        end else begin
          pending_openness.push_back(nearest_wall_openness(item));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_MAP_ROWS) rows_cfg = cfg_data;
        else if (cfg_index == REG_MAP_COLS) cols_cfg = cfg_data;
      end
    end
  end

  // Hold start across back-to-back beats; lower it only for a real gap.
  task automatic send_beat(input in_t beat);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= beat;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_cell(input int r, input int c, input bit w);
    in_t beat;
    beat.cmd = CMD_LOAD;
    beat.cell_row = CELL_W'(r);
    beat.cell_col = CELL_W'(c);
    beat.wall_bit = w;
    send_beat(beat);
  endtask

  task automatic query_cell(input int r, input int c);
    in_t beat;
    beat.cmd = CMD_QUERY;
    beat.cell_row = CELL_W'(r);
    beat.cell_col = CELL_W'(c);
    beat.wall_bit = 1'($urandom);
    send_beat(beat);
  endtask

  // Wait until the block is idle and every query has been checked.
  task automatic quiesce();
    start <= 1'b0;
    do @(posedge clk); while (busy || pending_openness.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(input int r, input int c);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAP_ROWS;
    cfg_data <= CFG_W'(r);
    @(posedge clk);
    cfg_index <= REG_MAP_COLS;
    cfg_data <= CFG_W'(c);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_rows = clamp_side(CFG_W'(r));
    cur_cols = clamp_side(CFG_W'(c));
  endtask

  task automatic test_reset_size();
    query_cell(0, 0);
    query_cell(20, 19);
    query_cell(39, 39);
    query_cell(40, 5);
    query_cell(63, 63);
  endtask

  task automatic test_small_walls();
    quiesce();
    set_size(5, 7);
    load_cell(2, 3, 1'b1);
    load_cell(0, 6, 1'b1);
    load_cell(4, 0, 1'b1);
    load_cell(2, 3, 1'b0);
    query_cell(2, 4);
    load_cell(2, 3, 1'b1);
    query_cell(2, 3);
    query_cell(1, 1);
    query_cell(4, 6);
    query_cell(5, 2);
  endtask

  // A wall stored outside the map must only show once the map grows over it.
  task automatic test_store_outside_map();
    quiesce();
    set_size(12, 12);
    load_cell(20, 20, 1'b1);
    query_cell(11, 11);
    quiesce();
    set_size(30, 30);
    query_cell(19, 19);
  endtask

  task automatic test_size_limits();
    quiesce();
    set_size(0, 0);
    query_cell(0, 0);
    query_cell(0, 1);
    quiesce();
    set_size(127, 127);
    query_cell(63, 63);
    query_cell(31, 32);
    load_cell(63, 0, 1'b1);
    query_cell(62, 1);
    quiesce();
    set_size(65, 1);
    query_cell(50, 0);
  endtask

  task automatic test_random_maps();
    in_t beat;
    logic [IN_W-1:0] raw;
    int pick;
    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      idle_on = (ph == 0) ? 1'b1 : 1'($urandom);
      case (ph)
        0: set_size(64, $urandom_range(1, 4));
        1: set_size($urandom_range(1, 4), 64);
        default: set_size($urandom_range(1, 16), $urandom_range(1, 16));
      endcase
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          load_cell($urandom_range(0, cur_rows - 1), $urandom_range(0, cur_cols - 1),
                    $urandom_range(0, 4) < 3);
        end else if (pick < 9) begin
          query_cell($urandom_range(0, cur_rows - 1), $urandom_range(0, cur_cols - 1));
        end else begin
          raw = IN_W'($urandom);
          beat = raw;
          send_beat(beat);
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // bitmap clear pass runs after reset
    do @(posedge clk); while (busy !== 1'b0);
    test_reset_size();
    test_small_walls();
    test_store_outside_map();
    test_size_limits();
    test_random_maps();
    quiesce();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
